// ===== src/lqm_pkg.sv =====
// Shared types, codes and constants of the queued exclusive lock manager.
package lqm_pkg;

   // Default FIFO depth of waiting requests
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Reset value of the per-client lock limit register
   localparam logic [7:0] MAX_LOCKS_RESET = 8'd4;

   // Operation codes
   localparam logic [2:0] OP_REQUEST    = 3'd0;
   localparam logic [2:0] OP_GRANT      = 3'd1;
   localparam logic [2:0] OP_REMOVE_ONE = 3'd2;
   localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
   localparam logic [2:0] OP_UNLOCK     = 3'd4;
   localparam logic [2:0] OP_CHECK      = 3'd5;

   // Result codes
   localparam logic [2:0] RC_OK         = 3'd0;
   localparam logic [2:0] RC_CARD       = 3'd1;
   localparam logic [2:0] RC_LIMIT      = 3'd2;
   localparam logic [2:0] RC_WAIT       = 3'd3;
   localparam logic [2:0] RC_NOT_OWNED  = 3'd4;
   localparam logic [2:0] RC_NOT_LOCKED = 3'd5;
   localparam logic [2:0] RC_NOT_FOUND  = 3'd6;
   localparam logic [2:0] RC_FULL       = 3'd7;

   // One operation, client_id in the low bits
   typedef struct packed {
      logic [31:0] current_time;
      logic        card_inserted;
      logic [15:0] lock_duration;
      logic [31:0] client_id;
   } item_type;

   // One result, result_code in the low bits
   typedef struct packed {
      logic [31:0] idle_since;
      logic        pending_any;
      logic [31:0] lock_until;
      logic [31:0] request_id;
      logic [2:0]  result_code;
   } result_type;

endpackage

// ===== src/lqm_queue_ram.sv =====
// Wait queue storage: client and duration per entry, one write and one registered read port.
module lqm_queue_ram #(
   parameter int QUEUE_DEPTH = lqm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  logic [31:0]                    wr_client,
   input  logic [15:0]                    wr_dur,
   input  logic                           rd_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output logic [31:0]                    rd_client,
   output logic [15:0]                    rd_dur
);

   logic [31:0] client_mem_ff [QUEUE_DEPTH];
   logic [15:0] dur_mem_ff    [QUEUE_DEPTH];
   logic [31:0] rd_client_ff;
   logic [15:0] rd_dur_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         client_mem_ff[wr_addr] <= wr_client;
         dur_mem_ff[wr_addr]    <= wr_dur;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_client_ff <= client_mem_ff[rd_addr];
         rd_dur_ff    <= dur_mem_ff[rd_addr];
      end
   end

   assign rd_client = rd_client_ff;
   assign rd_dur    = rd_dur_ff;

endmodule

// ===== src/lqm_seq.sv =====
// Operation sequencer: holder state, queue walk with one shared client compare, result build.
module lqm_seq #(
   parameter int QUEUE_DEPTH = lqm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  logic [2:0]                     item_op,
   input  lqm_pkg::item_type              item,
   input  logic [7:0]                     max_locks,
   output logic                           ready,
   output logic                           done_valid,
   input  logic                           done_ack,
   output lqm_pkg::result_type            result,
   output logic                           rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   input  logic [31:0]                    rd_client,
   input  logic [15:0]                    rd_dur,
   output logic                           wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   output logic [31:0]                    wr_client,
   output logic [15:0]                    wr_dur
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int TALLY_W = $clog2(QUEUE_DEPTH + 3);
   localparam int LIM_W   = (TALLY_W > 8) ? TALLY_W : 8;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               holder_valid_ff, holder_valid_in;
   logic [31:0]        holder_client_ff, holder_client_in;
   logic [31:0]        next_id_ff, next_id_in;
   logic [31:0]        unused_ff, unused_in;
   logic [2:0]         op_ff, op_in;
   logic [31:0]        clid_ff, clid_in;
   logic [15:0]        dur_ff, dur_in;
   logic [31:0]        now_ff, now_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               dv_ff, dv_in;
   logic [CNT_W-1:0]   w_ptr_ff, w_ptr_in;
   logic               found_ff, found_in;
   logic               grant_ff, grant_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [15:0]        head_dur_ff, head_dur_in;
   logic [2:0]         rc_ff, rc_in;
   logic [31:0]        rid_ff, rid_in;
   logic [31:0]        until_ff, until_in;

   logic hmatch;
   logic match;
   logic issue;
   logic proc_head;
   logic skip;
   logic idle_after;

   // holder ownership of the incoming client
   assign hmatch = holder_valid_ff && (holder_client_ff == item.client_id);

   // shared queue-entry compare
   assign match = (rd_client == clid_ff);

   assign issue     = (state_ff == S_WALK) && (rd_ptr_ff < count_ff);
   assign proc_head = (rd_ptr_ff == CNT_W'(1));
   assign idle_after = (w_ptr_ff == '0) && !holder_valid_ff && (unused_ff == '0);

   // entry dropped during compaction
   always_comb begin
      case (op_ff)
         lqm_pkg::OP_GRANT:      skip = proc_head && match && !holder_valid_ff;
         lqm_pkg::OP_REMOVE_ONE: skip = match && !found_ff;
         lqm_pkg::OP_REMOVE_ALL: skip = match;
         default:                skip = 1'b0;
      endcase
   end

   // read port drive
   assign rd_en   = issue;
   assign rd_addr = rd_ptr_ff[IDX_W-1:0];

   // next state and write port
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      holder_valid_in  = holder_valid_ff;
      holder_client_in = holder_client_ff;
      next_id_in       = next_id_ff;
      unused_in        = unused_ff;
      op_in            = op_ff;
      clid_in          = clid_ff;
      dur_in           = dur_ff;
      now_in           = now_ff;
      rd_ptr_in        = rd_ptr_ff;
      dv_in            = 1'b0;
      w_ptr_in         = w_ptr_ff;
      found_in         = found_ff;
      grant_in         = grant_ff;
      tally_in         = tally_ff;
      head_dur_in      = head_dur_ff;
      rc_in            = rc_ff;
      rid_in           = rid_ff;
      until_in         = until_ff;
      wr_en            = 1'b0;
      wr_addr          = w_ptr_ff[IDX_W-1:0];
      wr_client        = rd_client;
      wr_dur           = rd_dur;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               op_in     = item_op;
               clid_in   = item.client_id;
               dur_in    = item.lock_duration;
               now_in    = item.current_time;
               rc_in     = lqm_pkg::RC_OK;
               rid_in    = '0;
               until_in  = '0;
               rd_ptr_in = '0;
               w_ptr_in  = '0;
               found_in  = 1'b0;
               grant_in  = 1'b0;
               tally_in  = TALLY_W'(hmatch);
               state_in  = S_DONE;
               case (item_op)
                  lqm_pkg::OP_REQUEST: begin
                     if (!item.card_inserted) begin
                        rc_in = lqm_pkg::RC_CARD;
                     end else begin
                        if (next_id_ff == '0) next_id_in = item.current_time;
                        state_in = S_WALK;
                     end
                  end
                  lqm_pkg::OP_GRANT: begin
                     if (!item.card_inserted) begin
                        rc_in = lqm_pkg::RC_CARD;
                     end else if (count_ff == '0) begin
                        rc_in = lqm_pkg::RC_NOT_FOUND;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  lqm_pkg::OP_REMOVE_ONE: begin
                     if (count_ff == '0) begin
                        rc_in = lqm_pkg::RC_NOT_FOUND;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  lqm_pkg::OP_REMOVE_ALL: begin
                     if (count_ff != '0 || holder_valid_ff) begin
                        if (hmatch) begin
                           holder_valid_in  = 1'b0;
                           holder_client_in = '0;
                        end
                        state_in = S_WALK;
                     end
                  end
                  lqm_pkg::OP_UNLOCK: begin
                     if (hmatch) begin
                        holder_valid_in  = 1'b0;
                        holder_client_in = '0;
                        if (count_ff == '0 && unused_ff == '0) unused_in = item.current_time;
                     end else begin
                        rc_in = lqm_pkg::RC_NOT_OWNED;
                     end
                  end
                  lqm_pkg::OP_CHECK: begin
                     if (!hmatch) rc_in = lqm_pkg::RC_NOT_LOCKED;
                  end
                  default: begin
                     rc_in = lqm_pkg::RC_OK;
                  end
               endcase
            end
         end

         // one entry read per cycle, previous entry compared and compacted
         S_WALK: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               if (op_ff == lqm_pkg::OP_REQUEST && match) tally_in = tally_ff + TALLY_W'(1);
               if (op_ff == lqm_pkg::OP_GRANT && proc_head) begin
                  grant_in    = skip;
                  head_dur_in = rd_dur;
               end
               if (op_ff == lqm_pkg::OP_REMOVE_ONE && match) found_in = 1'b1;
               if (op_ff != lqm_pkg::OP_REQUEST && !skip) begin
                  wr_en    = 1'b1;
                  w_ptr_in = w_ptr_ff + CNT_W'(1);
               end
            end
            if (!issue && !dv_ff) state_in = S_FINISH;
         end

         S_FINISH: begin
            state_in = S_DONE;
            case (op_ff)
               lqm_pkg::OP_REQUEST: begin
                  if ((LIM_W'(tally_ff) + LIM_W'(1)) >= LIM_W'(max_locks)) begin
                     rc_in = lqm_pkg::RC_LIMIT;
                  end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rc_in = lqm_pkg::RC_FULL;
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = count_ff[IDX_W-1:0];
                     wr_client  = clid_ff;
                     wr_dur     = dur_ff;
                     rid_in     = next_id_ff;
                     next_id_in = next_id_ff + 32'd1;
                     count_in   = count_ff + CNT_W'(1);
                     unused_in  = '0;
                  end
               end
               lqm_pkg::OP_GRANT: begin
                  if (grant_ff) begin
                     holder_valid_in  = 1'b1;
                     holder_client_in = clid_ff;
                     until_in         = now_ff + 32'(head_dur_ff);
                     count_in         = w_ptr_ff;
                  end else begin
                     rc_in = lqm_pkg::RC_WAIT;
                  end
               end
               lqm_pkg::OP_REMOVE_ONE: begin
                  if (found_ff) begin
                     count_in = w_ptr_ff;
                     if (idle_after) unused_in = now_ff;
                  end else begin
                     rc_in = lqm_pkg::RC_NOT_FOUND;
                  end
               end
               lqm_pkg::OP_REMOVE_ALL: begin
                  count_in = w_ptr_ff;
                  if (idle_after) unused_in = now_ff;
               end
               default: begin
                  rc_in = rc_ff;
               end
            endcase
         end

         S_DONE: begin
            if (done_ack) state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         holder_valid_ff  <= 1'b0;
         holder_client_ff <= '0;
         next_id_ff       <= '0;
         unused_ff        <= '0;
         dv_ff            <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         holder_valid_ff  <= holder_valid_in;
         holder_client_ff <= holder_client_in;
         next_id_ff       <= next_id_in;
         unused_ff        <= unused_in;
         dv_ff            <= dv_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      clid_ff     <= clid_in;
      dur_ff      <= dur_in;
      now_ff      <= now_in;
      rd_ptr_ff   <= rd_ptr_in;
      w_ptr_ff    <= w_ptr_in;
      found_ff    <= found_in;
      grant_ff    <= grant_in;
      tally_ff    <= tally_in;
      head_dur_ff <= head_dur_in;
      rc_ff       <= rc_in;
      rid_ff      <= rid_in;
      until_ff    <= until_in;
   end

   assign ready      = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);

   always_comb begin
      result.result_code = rc_ff;
      result.request_id  = rid_ff;
      result.lock_until  = until_ff;
      result.pending_any = holder_valid_ff || (count_ff != '0);
      result.idle_since  = unused_ff;
   end

endmodule

// ===== src/queued_exclusive_lock_manager.sv =====
// Top level of the queued exclusive lock manager: ports, limit register, output register.
// Request, grant check, remove one and remove all walk the wait queue; other operations do not.
// One item at a time: the next is accepted once the result has moved to the output register,
//   so output stalls hold back new items; the walk reads one queue entry per cycle.
// Reset: empties the queue, drops the holder, clears id seed and idle stamp, max_locks = 4.
module queued_exclusive_lock_manager #(
   parameter int QUEUE_DEPTH = lqm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // client_id, lock_duration, card_inserted, current_time
   input  logic [2:0]   req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // result_code, request_id, lock_until, pending_any,
                                     // idle_since
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [7:0]          max_locks_ff;
   logic                rsp_valid_ff;
   lqm_pkg::result_type rsp_data_ff;

   lqm_pkg::item_type   item;
   lqm_pkg::result_type result;
   logic                seq_ready;
   logic                done_valid;
   logic                done_ack;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [31:0]         rd_client;
   logic [15:0]         rd_dur;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [31:0]         wr_client;
   logic [15:0]         wr_dur;

   // unpack input transfer
   always_comb begin
      item.client_id     = req_tdata[31:0];
      item.lock_duration = req_tdata[47:32];
      item.card_inserted = req_tdata[48];
      item.current_time  = req_tdata[80:49];
   end

   assign req_tready = seq_ready;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_locks_ff <= lqm_pkg::MAX_LOCKS_RESET;
      end else if (csr_wr_en) begin
         max_locks_ff <= csr_wr_data;
      end
   end

   lqm_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid && seq_ready),
      .item_op    (req_tuser),
      .item       (item),
      .max_locks  (max_locks_ff),
      .ready      (seq_ready),
      .done_valid (done_valid),
      .done_ack   (done_ack),
      .result     (result),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_client  (rd_client),
      .rd_dur     (rd_dur),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_client  (wr_client),
      .wr_dur     (wr_dur)
   );

   lqm_queue_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_client (wr_client),
      .wr_dur    (wr_dur),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_client (rd_client),
      .rd_dur    (rd_dur)
   );

   // output register, loaded when empty or being drained
   assign done_ack = done_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_ack) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

endmodule

// ===== src/lqm_checker.sv =====
// Port-level checks of the queued exclusive lock manager, bound to the top level.
module lqm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   // a held result stays put until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // one operation at a time: busy right after an accepted transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an operation is in progress");

   // ids and lock times only come with a successful result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != lqm_pkg::RC_OK)
         |-> (rsp_tdata[34:3] == 32'd0) && (rsp_tdata[66:35] == 32'd0))
      else $error("request id or lock time on a failed operation");

   // a granted lock leaves the resource in use
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[66:35] != 32'd0) |-> rsp_tdata[67])
      else $error("lock granted but nothing pending");

   // after reset the block is ready and has no result
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind queued_exclusive_lock_manager lqm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the queued exclusive lock manager.
module testbench;

   // Operation codes the block ignores
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [87:0]  req_tdata;   // client_id, lock_duration, card_inserted, current_time
   logic [2:0]   req_tuser;   // operation
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // result_code, request_id, lock_until, pending_any, idle_since
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;

   queued_exclusive_lock_manager i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted lock state
   logic [31:0] fifo_client[$];
   logic [15:0] fifo_dur[$];
   logic        owner_valid = 1'b0;
   logic [31:0] owner_id    = '0;
   logic [31:0] owner_until = '0;
   logic [31:0] id_counter  = '0;
   logic [31:0] idle_stamp  = '0;
   logic [7:0]  limit_reg   = lqm_pkg::MAX_LOCKS_RESET;

   lqm_pkg::result_type expected_lock_results[$];
   int         mismatch_count = 0;
   int         send_idle_pct  = 0;
   int         recv_stall_pct = 0;
   logic [31:0] now_sec       = '0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // Stamp the idle time once nothing is held or queued
   function automatic void settle_idle(input logic [31:0] now);
      if (fifo_client.size() == 0 && !owner_valid && idle_stamp == 0)
         idle_stamp = now;
   endfunction

   // Expected result of one operation; advances the predicted state
   function automatic lqm_pkg::result_type predict_lock_result(input logic [2:0] op,
                                                               input lqm_pkg::item_type it);
      lqm_pkg::result_type r;
      int          held;
      int          pos;
      logic [31:0] keep_c[$];
      logic [15:0] keep_d[$];
      r = '0;
      case (op)
         lqm_pkg::OP_REQUEST: begin
            if (!it.card_inserted) begin
               r.result_code = lqm_pkg::RC_CARD;
            end else begin
               if (id_counter == 0)
                  id_counter = it.current_time;
               held = (owner_valid && owner_id == it.client_id) ? 1 : 0;
               foreach (fifo_client[i])
                  if (fifo_client[i] == it.client_id)
                     held++;
               if (held + 1 >= int'(limit_reg)) begin
                  r.result_code = lqm_pkg::RC_LIMIT;
               end else if (fifo_client.size() >= lqm_pkg::DEFAULT_QUEUE_DEPTH) begin
                  r.result_code = lqm_pkg::RC_FULL;
               end else begin
                  r.request_id = id_counter;
                  id_counter   = id_counter + 1;
                  fifo_client.push_back(it.client_id);
                  fifo_dur.push_back(it.lock_duration);
                  idle_stamp = '0;
               end
            end
         end
         lqm_pkg::OP_GRANT: begin
            if (!it.card_inserted) begin
               r.result_code = lqm_pkg::RC_CARD;
            end else if (fifo_client.size() == 0) begin
               r.result_code = lqm_pkg::RC_NOT_FOUND;
            end else if (fifo_client[0] == it.client_id && !owner_valid) begin
               owner_valid  = 1'b1;
               owner_id     = it.client_id;
               owner_until  = it.current_time + {16'h0, fifo_dur[0]};
               r.lock_until = owner_until;
               void'(fifo_client.pop_front());
               void'(fifo_dur.pop_front());
            end else begin
               r.result_code = lqm_pkg::RC_WAIT;
            end
         end
         lqm_pkg::OP_REMOVE_ONE: begin
            pos = -1;
            foreach (fifo_client[i])
               if (pos < 0 && fifo_client[i] == it.client_id)
                  pos = i;
            if (pos < 0) begin
               r.result_code = lqm_pkg::RC_NOT_FOUND;
            end else begin
               fifo_client.delete(pos);
               fifo_dur.delete(pos);
               settle_idle(it.current_time);
            end
         end
         lqm_pkg::OP_REMOVE_ALL: begin
            if (fifo_client.size() != 0 || owner_valid) begin
               if (owner_valid && owner_id == it.client_id) begin
                  owner_valid = 1'b0;
                  owner_id    = '0;
                  owner_until = '0;
               end
               foreach (fifo_client[i])
                  if (fifo_client[i] != it.client_id) begin
                     keep_c.push_back(fifo_client[i]);
                     keep_d.push_back(fifo_dur[i]);
                  end
               fifo_client = keep_c;
               fifo_dur    = keep_d;
               settle_idle(it.current_time);
            end
         end
         lqm_pkg::OP_UNLOCK: begin
            if (owner_valid && owner_id == it.client_id) begin
               owner_valid = 1'b0;
               owner_id    = '0;
               owner_until = '0;
               settle_idle(it.current_time);
            end else begin
               r.result_code = lqm_pkg::RC_NOT_OWNED;
            end
         end
         lqm_pkg::OP_CHECK: begin
            if (!(owner_valid && owner_id == it.client_id))
               r.result_code = lqm_pkg::RC_NOT_LOCKED;
         end
         default: ;
      endcase
      r.pending_any = owner_valid || fifo_client.size() != 0;
      r.idle_since  = idle_stamp;
      return r;
   endfunction

   // Receiver backpressure, redrawn every cycle
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Result checker: each transfer against the oldest expectation
   always @(posedge clock) begin
      lqm_pkg::result_type got;
      lqm_pkg::result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata[$bits(lqm_pkg::result_type)-1:0];
         if (expected_lock_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_lock_results.pop_front();
            check_field("result_code", 32'(want.result_code), 32'(got.result_code));
            check_field("request_id", want.request_id, got.request_id);
            check_field("lock_until", want.lock_until, got.lock_until);
            check_field("pending_any", 32'(want.pending_any), 32'(got.pending_any));
            check_field("idle_since", want.idle_since, got.idle_since);
         end
      end
   end

   // Send one operation; called and returns at a falling edge, tvalid left high
   task automatic send_op(input logic [2:0] op, input logic [31:0] client,
                          input logic [15:0] dur, input logic card,
                          input logic [31:0] now);
      lqm_pkg::item_type it;
      it.client_id     = client;
      it.lock_duration = dur;
      it.card_inserted = card;
      it.current_time  = now;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, it};
      req_tuser  <= op;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      expected_lock_results.push_back(predict_lock_result(op, it));
      @(negedge clock);
   endtask

   // Stop sending and wait until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_lock_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_lock_limit(input logic [7:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      limit_reg = value;
   endtask

   // Edge values of every field and each special case, at the reset limit
   task automatic test_directed();
      send_op(lqm_pkg::OP_GRANT,      32'd5, 16'd0, 1'b1, 32'd100);   // empty queue
      send_op(lqm_pkg::OP_REQUEST,    32'd5, 16'd9, 1'b0, 32'd100);   // no card
      send_op(lqm_pkg::OP_GRANT,      32'd5, 16'd0, 1'b0, 32'd100);
      send_op(lqm_pkg::OP_REMOVE_ALL, 32'd5, 16'd0, 1'b1, 32'd110);   // nothing to do
      send_op(lqm_pkg::OP_REMOVE_ONE, 32'd5, 16'd0, 1'b1, 32'd120);
      send_op(lqm_pkg::OP_UNLOCK,     32'd5, 16'd0, 1'b1, 32'd130);
      send_op(lqm_pkg::OP_CHECK,      32'd5, 16'd0, 1'b1, 32'd140);
      send_op(OP_SPARE_6,             '1, '1, 1'b1, '1);
      send_op(OP_SPARE_7,             '1, '1, 1'b1, '1);
      // id seeded near the top, wraps to zero and is seeded again
      send_op(lqm_pkg::OP_REQUEST,    32'd0, 16'd0, 1'b1, 32'hFFFF_FFFE);
      send_op(lqm_pkg::OP_REQUEST,    '1, '1, 1'b1, '1);
      send_op(lqm_pkg::OP_REQUEST,    32'd0, 16'h1234, 1'b1, 32'd0);
      send_op(lqm_pkg::OP_GRANT,      '1, 16'd0, 1'b1, 32'd150);      // head is another client
      send_op(lqm_pkg::OP_GRANT,      32'd0, 16'd0, 1'b1, 32'hFFFF_FFF0);
      send_op(lqm_pkg::OP_REQUEST,    32'd0, 16'd7, 1'b1, 32'd160);
      send_op(lqm_pkg::OP_REQUEST,    32'd0, 16'd7, 1'b1, 32'd170);   // over the limit
      send_op(lqm_pkg::OP_GRANT,      '1, 16'd0, 1'b1, 32'd180);      // lock held
      send_op(lqm_pkg::OP_CHECK,      32'd0, 16'd0, 1'b1, 32'd190);
      send_op(lqm_pkg::OP_UNLOCK,     '1, 16'd0, 1'b1, 32'd200);
      send_op(lqm_pkg::OP_UNLOCK,     32'd0, 16'd0, 1'b1, 32'd300);
      send_op(lqm_pkg::OP_GRANT,      '1, 16'd0, 1'b1, 32'hFFFF_8000); // expiry wraps
      send_op(lqm_pkg::OP_REMOVE_ONE, 32'd0, 16'd0, 1'b1, 32'd400);
      send_op(lqm_pkg::OP_REMOVE_ALL, '1, 16'd0, 1'b1, 32'd500);      // drops the holder
      send_op(lqm_pkg::OP_REMOVE_ALL, 32'd0, 16'd0, 1'b1, 32'd600);   // now idle
      send_op(lqm_pkg::OP_REMOVE_ONE, 32'd0, 16'd0, 1'b1, 32'd650);   // stamp kept
   endtask

   // Limit extremes and a full queue
   task automatic test_limit_extremes();
      set_lock_limit(8'd0);
      send_op(lqm_pkg::OP_REQUEST, 32'd9, 16'd1, 1'b1, 32'd700);
      set_lock_limit(8'd1);
      send_op(lqm_pkg::OP_REQUEST, 32'd9, 16'd1, 1'b1, 32'd710);
      set_lock_limit(8'd2);
      send_op(lqm_pkg::OP_REQUEST, 32'd9, 16'd1, 1'b1, 32'd720);
      send_op(lqm_pkg::OP_REQUEST, 32'd9, 16'd1, 1'b1, 32'd730);
      send_op(lqm_pkg::OP_REMOVE_ALL, 32'd9, 16'd0, 1'b1, 32'd740);
      set_lock_limit(8'd255);
      for (int n = 0; n <= lqm_pkg::DEFAULT_QUEUE_DEPTH; n++)
         send_op(lqm_pkg::OP_REQUEST, 32'hA5A5_0001, 16'(n * 4099), 1'b1, 32'd800 + n);
      send_op(lqm_pkg::OP_GRANT,   32'hA5A5_0001, 16'd0, 1'b1, 32'd900);
      send_op(lqm_pkg::OP_REQUEST, 32'h5A5A_0002, 16'd3, 1'b1, 32'd910);
      send_op(lqm_pkg::OP_REQUEST, 32'h5A5A_0002, 16'd3, 1'b1, 32'd920);
      send_op(lqm_pkg::OP_REMOVE_ALL, 32'hA5A5_0001, 16'd0, 1'b1, 32'd930);
      send_op(lqm_pkg::OP_REMOVE_ALL, 32'h5A5A_0002, 16'd0, 1'b1, 32'd940);
   endtask

   // Mostly well-formed lock traffic among a few clients
   task automatic run_random_phase(input int count, input int idle_pct,
                                   input int stall_pct, input logic [7:0] limit);
      logic [31:0] pool[4];
      logic [31:0] client;
      logic [2:0]  op;
      int          pick;
      set_lock_limit(limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      pool[0] = '0;
      pool[1] = '1;
      pool[2] = $urandom;
      pool[3] = $urandom;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 34)      op = lqm_pkg::OP_REQUEST;
         else if (pick < 60) op = lqm_pkg::OP_GRANT;
         else if (pick < 70) op = lqm_pkg::OP_REMOVE_ONE;
         else if (pick < 76) op = lqm_pkg::OP_REMOVE_ALL;
         else if (pick < 86) op = lqm_pkg::OP_UNLOCK;
         else if (pick < 96) op = lqm_pkg::OP_CHECK;
         else                op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
         if ($urandom_range(99) < 8)
            client = $urandom;
         else
            client = pool[$urandom_range(3)];
         if (op == lqm_pkg::OP_GRANT && fifo_client.size() != 0 && $urandom_range(99) < 70)
            client = fifo_client[0];
         if ((op == lqm_pkg::OP_UNLOCK || op == lqm_pkg::OP_CHECK) && owner_valid &&
             $urandom_range(99) < 60)
            client = owner_id;
         if ($urandom_range(99) < 5)
            now_sec = $urandom;
         else
            now_sec = now_sec + $urandom_range(40);
         send_op(op, client, 16'($urandom), ($urandom_range(99) < 92), now_sec);
      end
   endtask

   task automatic test_random();
      run_random_phase(100, 0, 0, 8'd3);
      run_random_phase(100, 79, 0, 8'd255);
      run_random_phase(100, 0, 79, 8'd5);
      run_random_phase(100, 7, 7, 8'd16);
   endtask

   // Test sequence
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_limit_extremes();
      test_random();
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && expected_lock_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== queued_exclusive_lock_manager.f =====
src/lqm_pkg.sv
src/lqm_queue_ram.sv
src/lqm_seq.sv
src/queued_exclusive_lock_manager.sv
src/lqm_checker.sv
dv/testbench.sv
